// ----- hdl/gtdf_pkg.sv -----
`timescale 1ns / 1ps

package gtdf_pkg;

  localparam int BUTTONS         = 8;
  localparam int RATE_BITS       = 6;
  localparam int RATES_WIDTH     = BUTTONS * RATE_BITS;
  localparam int ENABLE_WIDTH    = 2 * BUTTONS;
  localparam int HOLD_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = RATES_WIDTH;

  localparam int RATE_MIN_DEFAULT    = 2;
  localparam int RATE_MAX_DEFAULT    = 63;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  typedef logic [RATE_BITS-1:0]   rate_t;
  typedef logic [BUTTONS-1:0]     pad_byte_t;
  typedef logic [RATES_WIDTH-1:0] rates_t;
  typedef logic [HOLD_WIDTH-1:0]  hold_t;

  localparam rate_t     DEFAULT_RATE = 6'd10;
  localparam pad_byte_t MASK_RESET   = 8'hAF;
  localparam pad_byte_t PAIR_HI      = 8'hC0;
  localparam pad_byte_t PAIR_LO      = 8'h30;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_TURBO_ENABLE = 8'd0,
    REG_RATES_PAD0   = 8'd1,
    REG_RATES_PAD1   = 8'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  function automatic rates_t default_rates();
    rates_t r;
    for (int b = 0; b < BUTTONS; b++) begin
      r[b*RATE_BITS +: RATE_BITS] = DEFAULT_RATE;
    end
    return r;
  endfunction

  // limit to the maximum first, then the minimum: the minimum wins on conflict
  function automatic rates_t clamp_rates(rates_t v, rate_t rmin, rate_t rmax);
    rates_t r;
    rate_t  f;
    for (int b = 0; b < BUTTONS; b++) begin
      f = v[b*RATE_BITS +: RATE_BITS];
      if (f > rmax) f = rmax;
      if (f < rmin) f = rmin;
      r[b*RATE_BITS +: RATE_BITS] = f;
    end
    return r;
  endfunction

endpackage

// ----- hdl/gtdf_if.sv -----
`timescale 1ns / 1ps

interface gtdf_poll_if;
  import gtdf_pkg::*;

  logic      valid;
  logic      ready;
  logic      pad_select;
  pad_byte_t pressed_bits;
  pad_byte_t suppress_bits;
  hold_t     hold_count_0;
  hold_t     hold_count_1;
  hold_t     hold_count_2;
  hold_t     hold_count_3;
  hold_t     hold_count_4;
  hold_t     hold_count_5;
  hold_t     hold_count_6;
  hold_t     hold_count_7;

  modport source (
    output valid, pad_select, pressed_bits, suppress_bits,
           hold_count_0, hold_count_1, hold_count_2, hold_count_3,
           hold_count_4, hold_count_5, hold_count_6, hold_count_7,
    input  ready
  );

  modport sink (
    input  valid, pad_select, pressed_bits, suppress_bits,
           hold_count_0, hold_count_1, hold_count_2, hold_count_3,
           hold_count_4, hold_count_5, hold_count_6, hold_count_7,
    output ready
  );
endinterface

interface gtdf_result_if;
  import gtdf_pkg::*;

  logic      valid;
  logic      ready;
  pad_byte_t pad_byte;

  modport source (output valid, pad_byte, input ready);
  modport sink   (input valid, pad_byte, output ready);
endinterface

// ----- hdl/gtdf_lane.sv -----
`timescale 1ns / 1ps

module gtdf_lane #(
  parameter int COUNT_WIDTH = gtdf_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  gtdf_pkg::lane_ctrl_t   ctrl,
  input  logic                   button_in,
  input  logic                   turbo_in,
  input  gtdf_pkg::rate_t        rate_in,
  input  logic [COUNT_WIDTH-1:0] count_in,
  output logic                   button_on
);
  import gtdf_pkg::*;

  logic                   on_q;
  logic                   turbo_q;
  rate_t                  rate_q;
  rate_t                  rem;
  logic [COUNT_WIDTH-1:0] count_sh;
  logic [RATE_BITS:0]     partial;

  // restoring remainder: bring in one count bit per step, subtract when it fits
  assign partial = {rem, count_sh[COUNT_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      on_q     <= button_in;
      turbo_q  <= turbo_in;
      rate_q   <= (rate_in == '0) ? rate_t'(1) : rate_in;
      rem      <= '0;
      count_sh <= count_in;
    end else if (ctrl.step) begin
      if (partial >= {1'b0, rate_q}) begin
        rem <= rate_t'(partial - {1'b0, rate_q});
      end else begin
        rem <= partial[RATE_BITS-1:0];
      end
      count_sh <= {count_sh[COUNT_WIDTH-2:0], 1'b0};
    end
  end

  assign button_on = on_q && !(turbo_q && (rem >= (rate_q >> 1)));

endmodule

// ----- hdl/gtdf_merge.sv -----
`timescale 1ns / 1ps

module gtdf_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                pad,
  input  gtdf_pkg::pad_byte_t cur,
  output gtdf_pkg::pad_byte_t filtered
);
  import gtdf_pkg::*;

  pad_byte_t previous_byte [2];
  pad_byte_t direction_mask [2];
  pad_byte_t changed;
  pad_byte_t hidden;
  pad_byte_t mask_next;

  always_comb begin
    changed   = cur ^ previous_byte[pad];
    hidden    = cur & ~direction_mask[pad];
    mask_next = direction_mask[pad];
    // flip a pair's mask when the pair moved and one of its bits is hidden
    if (|(changed & PAIR_HI) && |(hidden & PAIR_HI)) mask_next = mask_next ^ PAIR_HI;
    if (|(changed & PAIR_LO) && |(hidden & PAIR_LO)) mask_next = mask_next ^ PAIR_LO;
    filtered = cur & mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte[0]  <= '0;
      previous_byte[1]  <= '0;
      direction_mask[0] <= MASK_RESET;
      direction_mask[1] <= MASK_RESET;
    end else if (fire) begin
      previous_byte[pad]  <= cur;
      direction_mask[pad] <= mask_next;
    end
  end

endmodule

// ----- hdl/gamepad_turbo_direction_filter.sv -----
`timescale 1ns / 1ps

// Turbo and opposing-direction filter for two 8-button pads. A poll is taken
// when the block is idle; eight button lanes then each work out the hold count
// modulo the button's turbo rate one count bit per cycle. A poll runs from
// acceptance through these steps: loading the lanes, COUNT_WIDTH remainder
// steps, and a merge step that builds the byte, updates the pad's direction
// mask and loads the output register. The result register lets the next poll
// start while a result still waits; the merge step holds for as long as an
// earlier result has not been taken. Rate writes are clamped to
// [RATE_MIN, RATE_MAX] per 6-bit field; configure only while no poll is in
// flight.
module gamepad_turbo_direction_filter #(
  parameter int RATE_MIN    = gtdf_pkg::RATE_MIN_DEFAULT,
  parameter int RATE_MAX    = gtdf_pkg::RATE_MAX_DEFAULT,
  parameter int COUNT_WIDTH = gtdf_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gtdf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [gtdf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  gtdf_poll_if.sink                            poll,
  gtdf_result_if.source                        result
);
  import gtdf_pkg::*;

  localparam int STEP_BITS = $clog2(COUNT_WIDTH);

  typedef enum logic [1:0] {IDLE, RUN, MERGE} state_t;

  state_t                 state;
  logic [STEP_BITS-1:0]   step_cnt;
  logic                   pad_q;
  logic                   out_valid;
  pad_byte_t              out_byte;
  logic [ENABLE_WIDTH-1:0] turbo_enable;
  rates_t                 rates_pad0;
  rates_t                 rates_pad1;
  rates_t                 rates_sel;
  pad_byte_t              enables_sel;
  hold_t                  holds [BUTTONS];
  lane_ctrl_t             lane_ctrl;
  pad_byte_t              cur;
  pad_byte_t              filtered;
  logic                   accept;
  logic                   fire;

  assign poll.ready    = (state == IDLE);
  assign accept        = poll.valid && poll.ready;
  assign fire          = (state == MERGE) && (!out_valid || result.ready);
  assign result.valid  = out_valid;
  assign result.pad_byte = out_byte;

  assign lane_ctrl.load = accept;
  assign lane_ctrl.step = (state == RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      turbo_enable <= '0;
      rates_pad0   <= default_rates();
      rates_pad1   <= default_rates();
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TURBO_ENABLE: turbo_enable <= cfg_data[ENABLE_WIDTH-1:0];
        REG_RATES_PAD0:   rates_pad0 <= clamp_rates(cfg_data, rate_t'(RATE_MIN),
                                                    rate_t'(RATE_MAX));
        REG_RATES_PAD1:   rates_pad1 <= clamp_rates(cfg_data, rate_t'(RATE_MIN),
                                                    rate_t'(RATE_MAX));
        default: ;
      endcase
    end
  end

  always_comb begin
    rates_sel   = poll.pad_select ? rates_pad1 : rates_pad0;
    enables_sel = poll.pad_select ? turbo_enable[ENABLE_WIDTH-1:BUTTONS]
                                  : turbo_enable[BUTTONS-1:0];
    holds[0] = poll.hold_count_0;
    holds[1] = poll.hold_count_1;
    holds[2] = poll.hold_count_2;
    holds[3] = poll.hold_count_3;
    holds[4] = poll.hold_count_4;
    holds[5] = poll.hold_count_5;
    holds[6] = poll.hold_count_6;
    holds[7] = poll.hold_count_7;
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    gtdf_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .button_in(poll.pressed_bits[b] && !poll.suppress_bits[b]),
      .turbo_in (enables_sel[b]),
      .rate_in  (rates_sel[b*RATE_BITS +: RATE_BITS]),
      .count_in (COUNT_WIDTH'(holds[b])),
      .button_on(cur[b])
    );
  end

  gtdf_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .pad     (pad_q),
    .cur     (cur),
    .filtered(filtered)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            pad_q    <= poll.pad_select;
            step_cnt <= '0;
            state    <= RUN;
          end
        end
        RUN: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_BITS'(COUNT_WIDTH - 1)) state <= MERGE;
        end
        MERGE: begin
          // hold until the output register is free
          if (fire) begin
            out_byte <= filtered;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
